>>> design/plst_pkg.sv
// ----------------------------------------------------------------------------
// plst_pkg
// shared widths, codes and control types of the positional list store
// ----------------------------------------------------------------------------
package plst_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int KIND_W = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 31;
  localparam int STAT_W = 2;
  localparam int CNTO_W = 7;

  // compare width covering both position and count
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [KIND_W-1:0] {
    K_INS_HEAD = 3'd0,
    K_INS_POS  = 3'd1,
    K_INS_TAIL = 3'd2,
    K_REM_HEAD = 3'd3,
    K_REM_POS  = 3'd4,
    K_REM_TAIL = 3'd5,
    K_READ     = 3'd6
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } stat_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_FETCH  = 8'b0000_0100,
    S_CATCH  = 8'b0000_1000,
    S_SHIFT  = 8'b0001_0000,
    S_DRAIN  = 8'b0010_0000,
    S_PUT    = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic idle;
    logic check;
    logic fetch;
    logic catch_val;
    logic shift;
    logic drain;
    logic put;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic req_valid;
    logic bad;
    logic ins;
    logic rd;
    logic ins_at_end;
    logic rem_at_end;
    logic last;
    logic out_free;
  } sts_t;

endpackage

>>> design/plst_req_if.sv
// ----------------------------------------------------------------------------
// plst_req_if
// request channel: kind, position and handle with valid/ready
// ----------------------------------------------------------------------------
interface plst_req_if;
  logic                         valid;
  logic                         ready;
  logic [plst_pkg::KIND_W-1:0]  kind;
  logic [plst_pkg::POS_W-1:0]   position;
  logic [plst_pkg::VAL_W-1:0]   value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

>>> design/plst_rsp_if.sv
// ----------------------------------------------------------------------------
// plst_rsp_if
// response channel: status, handle and count with valid/ready
// ----------------------------------------------------------------------------
interface plst_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [plst_pkg::STAT_W-1:0]  status;
  logic [plst_pkg::VAL_W-1:0]   value_out;
  logic [plst_pkg::CNTO_W-1:0]  count_out;

  modport source (output valid, status, value_out, count_out, input ready);
  modport sink   (input valid, status, value_out, count_out, output ready);
endinterface

>>> design/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// ordered list of record handles with positional insert, remove and read
//
//   channel   dir   handshake      payload
//   in_req    in    valid/ready    kind, position, value
//   out_rsp   out   valid/ready    status, value_out, count_out
//
// one request at a time. a rejected request goes straight to its result, an
// insert at the tail writes its entry directly, and a read or a remove of the
// last entry moves nothing; any other insert or remove moves entries through
// the entry ram's single write port, one entry per cycle. synchronous active-low
// reset empties the list; entries need no clearing. a new request is taken
// while a result waits in the output register; a stalled output holds the
// next result in the sequencer.
// ----------------------------------------------------------------------------
module positional_list_store (
  input  logic        clk,
  input  logic        rst_n,
  plst_req_if.sink    in_req,
  plst_rsp_if.source  out_rsp
);

  plst_pkg::cmd_t cmd;
  plst_pkg::sts_t sts;

  plst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  plst_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

>>> design/plst_ram.sv
// ----------------------------------------------------------------------------
// plst_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module plst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/plst_ctrl.sv
// ----------------------------------------------------------------------------
// plst_ctrl
// sequencer for check, fetch, catch, shift, drain, put and result steps
// ----------------------------------------------------------------------------
module plst_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  plst_pkg::sts_t  sts,
  output plst_pkg::cmd_t  cmd
);

  plst_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plst_pkg::S_IDLE: begin
        if (sts.req_valid) state_nxt = plst_pkg::S_CHECK;
      end
      plst_pkg::S_CHECK: begin
        if (sts.bad) state_nxt = plst_pkg::S_RESULT;
        else if (sts.ins) state_nxt = sts.ins_at_end ? plst_pkg::S_PUT : plst_pkg::S_SHIFT;
        else state_nxt = plst_pkg::S_FETCH;
      end
      plst_pkg::S_FETCH: state_nxt = plst_pkg::S_CATCH;
      plst_pkg::S_CATCH: begin
        if (sts.rd || sts.rem_at_end) state_nxt = plst_pkg::S_RESULT;
        else state_nxt = plst_pkg::S_SHIFT;
      end
      plst_pkg::S_SHIFT: begin
        if (sts.last) state_nxt = plst_pkg::S_DRAIN;
      end
      plst_pkg::S_DRAIN: state_nxt = sts.ins ? plst_pkg::S_PUT : plst_pkg::S_RESULT;
      plst_pkg::S_PUT:   state_nxt = plst_pkg::S_RESULT;
      plst_pkg::S_RESULT: begin
        if (sts.out_free) state_nxt = plst_pkg::S_IDLE;
      end
      default: state_nxt = plst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.idle      = (state_r == plst_pkg::S_IDLE);
    cmd.check     = (state_r == plst_pkg::S_CHECK);
    cmd.fetch     = (state_r == plst_pkg::S_FETCH);
    cmd.catch_val = (state_r == plst_pkg::S_CATCH);
    cmd.shift     = (state_r == plst_pkg::S_SHIFT);
    cmd.drain     = (state_r == plst_pkg::S_DRAIN);
    cmd.put       = (state_r == plst_pkg::S_PUT);
    cmd.commit    = (state_r == plst_pkg::S_RESULT) && sts.out_free;
  end

endmodule

>>> design/plst_dp.sv
// ----------------------------------------------------------------------------
// plst_dp
// request registers, range checks, entry ram, shift pointer and output slot
// ----------------------------------------------------------------------------
module plst_dp (
  input  logic             clk,
  input  logic             rst_n,
  plst_req_if.sink         in_req,
  plst_rsp_if.source       out_rsp,
  input  plst_pkg::cmd_t   cmd,
  output plst_pkg::sts_t   sts
);

  localparam int IW = plst_pkg::IDX_W;
  localparam int CW = plst_pkg::CMP_W;

  plst_pkg::kind_t                kind_r;
  logic [plst_pkg::POS_W-1:0]     pos_r;
  logic [plst_pkg::VAL_W-1:0]     val_r;
  logic [plst_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]                  tgt_r;
  plst_pkg::stat_t                stat_r;
  logic [plst_pkg::VAL_W-1:0]     res_val_r;
  logic [IW-1:0]                  ptr_r;
  logic                           pend_r;
  logic [IW-1:0]                  pend_addr_r;
  logic                           out_valid_r;
  logic [plst_pkg::STAT_W-1:0]    out_stat_r;
  logic [plst_pkg::VAL_W-1:0]     out_val_r;
  logic [plst_pkg::CNTO_W-1:0]    out_cnt_r;

  logic [CW-1:0]                  pos_c, cnt_c, tgt_c;
  plst_pkg::stat_t                stat_c;
  logic                           is_ins, is_rd;
  logic                           we;
  logic [IW-1:0]                  waddr, raddr;
  logic [plst_pkg::VAL_W-1:0]     wdata, rdata;

  // range checks
  assign pos_c = CW'(pos_r);
  assign cnt_c = CW'(cnt_r);
  assign is_ins = (kind_r == plst_pkg::K_INS_HEAD) || (kind_r == plst_pkg::K_INS_POS) ||
                  (kind_r == plst_pkg::K_INS_TAIL);
  assign is_rd  = (kind_r == plst_pkg::K_READ);

  always_comb begin
    tgt_c  = '0;
    stat_c = plst_pkg::ST_BAD;
    unique case (kind_r)
      plst_pkg::K_INS_HEAD, plst_pkg::K_INS_POS, plst_pkg::K_INS_TAIL: begin
        if (kind_r == plst_pkg::K_INS_POS) tgt_c = pos_c;
        else if (kind_r == plst_pkg::K_INS_TAIL) tgt_c = cnt_c;
        if (tgt_c > cnt_c) stat_c = plst_pkg::ST_BAD;
        else if (cnt_c >= CW'(plst_pkg::DEPTH)) stat_c = plst_pkg::ST_FULL;
        else stat_c = plst_pkg::ST_DONE;
      end
      plst_pkg::K_REM_HEAD, plst_pkg::K_REM_POS, plst_pkg::K_REM_TAIL: begin
        if (kind_r == plst_pkg::K_REM_POS) tgt_c = pos_c;
        else if (kind_r == plst_pkg::K_REM_TAIL) tgt_c = cnt_c - CW'(1);
        if (cnt_c == '0) stat_c = plst_pkg::ST_BAD;
        else if (tgt_c >= cnt_c) stat_c = plst_pkg::ST_BAD;
        else stat_c = plst_pkg::ST_DONE;
      end
      plst_pkg::K_READ: begin
        tgt_c  = pos_c;
        stat_c = (pos_c >= cnt_c) ? plst_pkg::ST_BAD : plst_pkg::ST_DONE;
      end
      default: begin
        tgt_c  = '0;
        stat_c = plst_pkg::ST_BAD;
      end
    endcase
  end

  // status to controller
  always_comb begin
    sts            = '0;
    sts.req_valid  = in_req.valid;
    sts.bad        = (stat_c != plst_pkg::ST_DONE);
    sts.ins        = is_ins;
    sts.rd         = is_rd;
    sts.ins_at_end = (tgt_c == cnt_c);
    sts.rem_at_end = ((CW'(tgt_r) + CW'(1)) == cnt_c);
    sts.last       = is_ins ? (ptr_r == tgt_r) : (CW'(ptr_r) == (cnt_c - CW'(1)));
    sts.out_free   = !out_valid_r || out_rsp.ready;
  end

  assign in_req.ready = cmd.idle;

  // entry store access
  always_comb begin
    raddr = ptr_r;
    if (cmd.fetch) raddr = tgt_r;
    we    = (cmd.shift && pend_r) || cmd.drain || cmd.put;
    waddr = cmd.put ? tgt_r : pend_addr_r;
    wdata = cmd.put ? val_r : rdata;
  end

  plst_ram #(
    .WIDTH (plst_pkg::VAL_W),
    .DEPTH (plst_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // count after the request
  always_comb begin
    cnt_nxt = cnt_r;
    if (stat_r == plst_pkg::ST_DONE) begin
      if (is_ins) cnt_nxt = cnt_r + plst_pkg::CNT_W'(1);
      else if (!is_rd) cnt_nxt = cnt_r - plst_pkg::CNT_W'(1);
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    if (cmd.idle && in_req.valid) begin
      kind_r <= plst_pkg::kind_t'(in_req.kind);
      pos_r  <= in_req.position;
      val_r  <= in_req.value;
    end
    if (cmd.check) begin
      tgt_r     <= IW'(tgt_c);
      stat_r    <= stat_c;
      res_val_r <= '0;
      ptr_r     <= IW'(cnt_c - CW'(1));
    end
    if (cmd.catch_val) begin
      res_val_r <= rdata;
      ptr_r     <= tgt_r + IW'(1);
    end
    if (cmd.shift) begin
      pend_addr_r <= is_ins ? (ptr_r + IW'(1)) : (ptr_r - IW'(1));
      ptr_r       <= is_ins ? (ptr_r - IW'(1)) : (ptr_r + IW'(1));
    end
    if (cmd.commit) begin
      out_stat_r <= stat_r;
      out_val_r  <= res_val_r;
      out_cnt_r  <= plst_pkg::CNTO_W'(cnt_nxt);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) cnt_r <= cnt_nxt;
      if (cmd.shift) pend_r <= 1'b1;
      else if (cmd.drain || cmd.check) pend_r <= 1'b0;
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_rsp.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = out_stat_r;
  assign out_rsp.value_out = out_val_r;
  assign out_rsp.count_out = out_cnt_r;

endmodule

>>> dv/tb_positional_list_store.sv
// ----------------------------------------------------------------------------
// tb_positional_list_store
// self-checking bench for the positional list store: requests go in over the
// request channel with random gaps, every response is compared field by field
// with a queue-based model of the list kept in a small scoreboard class
// ----------------------------------------------------------------------------
module tb_positional_list_store;
  timeunit 1ns;
  timeprecision 1ps;

  import plst_pkg::*;

  localparam logic [KIND_W-1:0] K_UNUSED = 3'd7;
  localparam int ITEM_TARGET = 2000;
  localparam int IDLE_LIMIT  = 4000;
  localparam int PRINT_LIMIT = 40;

  typedef enum int {M_FILL, M_DRAIN, M_MIX} mix_t;

  typedef struct packed {
    stat_t             st;
    logic [VAL_W-1:0]  handle;
    logic [CNTO_W-1:0] cnt;
  } list_rsp_t;

  class list_scoreboard;
    logic [VAL_W-1:0] handles[$];
    list_rsp_t        pending_rsp[$];
    int               errors;
    int               kind_seen[8];
    int               stat_seen[4];
    int               peak;

    function int pending();
      return pending_rsp.size();
    endfunction

    function int length();
      return handles.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                               logic [VAL_W-1:0] val);
      list_rsp_t r;
      int        n;
      int        at;
      n        = handles.size();
      r.st     = ST_DONE;
      r.handle = '0;
      kind_seen[kind]++;
      case (kind)
        K_INS_HEAD, K_INS_POS, K_INS_TAIL: begin
          at = (kind == K_INS_HEAD) ? 0 : (kind == K_INS_TAIL) ? n : int'(pos);
          if (at > n) r.st = ST_BAD;
          else if (n >= DEPTH) r.st = ST_FULL;
          else handles.insert(at, val);
        end
        K_REM_HEAD, K_REM_POS, K_REM_TAIL: begin
          at = (kind == K_REM_HEAD) ? 0 : (kind == K_REM_TAIL) ? n - 1 : int'(pos);
          if (n == 0 || at >= n) begin
            r.st = ST_BAD;
          end else begin
            r.handle = handles[at];
            handles.delete(at);
          end
        end
        K_READ: begin
          if (int'(pos) >= n) r.st = ST_BAD;
          else r.handle = handles[pos];
        end
        default: r.st = ST_BAD;
      endcase
      r.cnt = CNTO_W'(handles.size());
      stat_seen[r.st]++;
      if (handles.size() > peak) peak = handles.size();
      pending_rsp.push_back(r);
    endfunction

    task check_result(logic [STAT_W-1:0] st, logic [VAL_W-1:0] handle,
                      logic [CNTO_W-1:0] cnt);
      list_rsp_t r;
      if (pending_rsp.size() == 0) begin
        report($sformatf("response with nothing pending (status %0d)", st));
      end else begin
        r = pending_rsp.pop_front();
        if (st !== r.st)
          report($sformatf("status %0d, expected %0d", st, r.st));
        if (handle !== r.handle)
          report($sformatf("value_out %h, expected %h", handle, r.handle));
        if (cnt !== r.cnt)
          report($sformatf("count_out %0d, expected %0d", cnt, r.cnt));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  int   sent;
  int   stall;
  int   idle_cycles;

  list_scoreboard sb;

  plst_req_if req_if ();
  plst_rsp_if rsp_if ();

  positional_list_store u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [VAL_W-1:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return {VAL_W{1'b1}};
    return VAL_W'($urandom());
  endfunction

  task automatic hold_off(int n);
    if (n > 0) begin
      req_if.valid    <= 1'b0;
      req_if.kind     <= KIND_W'($urandom());
      req_if.position <= POS_W'($urandom());
      req_if.value    <= VAL_W'($urandom());
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                      logic [VAL_W-1:0] val);
    req_if.valid    <= 1'b1;
    req_if.kind     <= kind;
    req_if.position <= pos;
    req_if.value    <= val;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(kind, pos, val);
    sent++;
    @(negedge clk);
    hold_off(pick_gap());
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  task automatic send_random(mix_t mix);
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    int                n;
    int                r;
    bit                ins;
    n = sb.length();
    r = $urandom_range(0, 99);
    if (r < 5) begin
      kind = KIND_W'($urandom_range(0, 7));
      pos  = POS_W'($urandom_range(0, 127));
    end else begin
      r   = $urandom_range(0, 99);
      ins = (mix == M_FILL) ? (r < 85) : (mix == M_DRAIN) ? (r < 20) : (r < 50);
      if (ins) begin
        case ($urandom_range(0, 2))
          0:       kind = K_INS_HEAD;
          1:       kind = K_INS_POS;
          default: kind = K_INS_TAIL;
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0:       kind = K_REM_HEAD;
          1:       kind = K_REM_POS;
          2:       kind = K_REM_TAIL;
          default: kind = K_READ;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 10) pos = POS_W'($urandom_range(0, 127));
      else if (ins && r < 18) pos = POS_W'(n);
      else if (ins) pos = POS_W'($urandom_range(0, n));
      else if (n > 0) pos = POS_W'($urandom_range(0, n - 1));
      else pos = POS_W'($urandom_range(0, 127));
    end
    send(kind, pos, pick_handle());
  endtask

  // response side: random back-pressure, sampled at the rising edge
  initial begin
    rsp_if.ready = 1'b0;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.status, rsp_if.value_out, rsp_if.count_out);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    mix_t mix;
    int   seg_len;
    bit   first;
    sb              = new();
    rst_n           = 1'b0;
    quiet           = 1'b0;
    sent            = 0;
    req_if.valid    = 1'b0;
    req_if.kind     = '0;
    req_if.position = '0;
    req_if.value    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list corner cases
    send(K_REM_HEAD, 7'd0, pick_handle());
    send(K_REM_TAIL, 7'd0, pick_handle());
    send(K_REM_POS, 7'd0, pick_handle());
    send(K_READ, 7'd0, pick_handle());
    send(K_INS_POS, 7'd1, pick_handle());
    send(K_UNUSED, 7'd0, pick_handle());
    // basic inserts, reads and removes
    send(K_INS_HEAD, 7'd0, {VAL_W{1'b1}});
    send(K_INS_TAIL, 7'd127, '0);
    send(K_INS_POS, 7'd1, 31'h2AAA_AAAA);
    send(K_INS_POS, 7'd3, 31'h5555_5555);
    send(K_INS_POS, 7'd0, 31'h1234_5678);
    send(K_READ, 7'd0, pick_handle());
    send(K_READ, 7'd4, pick_handle());
    send(K_READ, 7'd5, pick_handle());
    send(K_READ, 7'd127, pick_handle());
    send(K_INS_POS, 7'd127, pick_handle());
    send(K_REM_POS, 7'd5, pick_handle());
    send(K_REM_POS, 7'd2, pick_handle());
    send(K_REM_TAIL, 7'd64, pick_handle());
    send(K_REM_HEAD, 7'd64, pick_handle());
    send(K_REM_POS, 7'd0, pick_handle());
    send(K_UNUSED, 7'd127, {VAL_W{1'b1}});
    wait_drained();
    @(negedge clk);

    first = 1'b1;
    while (sent < ITEM_TARGET) begin
      if (first) begin
        mix     = M_FILL;
        seg_len = 120;
        quiet   = 1'b0;
      end else begin
        mix     = mix_t'($urandom_range(0, 2));
        seg_len = $urandom_range(20, 150);
        quiet   = ($urandom_range(0, 3) == 0);
      end
      first = 1'b0;
      repeat (seg_len) send_random(mix);
      if ($urandom_range(0, 4) == 0) begin
        wait_drained();
        @(negedge clk);
      end
    end

    req_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (3 * DEPTH) @(posedge clk);

    $display("covered %0d requests: ins head/pos/tail %0d/%0d/%0d, rem head/pos/tail %0d/%0d/%0d",
             sent, sb.kind_seen[K_INS_HEAD], sb.kind_seen[K_INS_POS], sb.kind_seen[K_INS_TAIL],
             sb.kind_seen[K_REM_HEAD], sb.kind_seen[K_REM_POS], sb.kind_seen[K_REM_TAIL]);
    $display("reads %0d, unknown kind %0d; done %0d, rejected %0d, full %0d; peak %0d of %0d",
             sb.kind_seen[K_READ], sb.kind_seen[K_UNUSED], sb.stat_seen[ST_DONE],
             sb.stat_seen[ST_BAD], sb.stat_seen[ST_FULL], sb.peak, DEPTH);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
